[src/wpta_pkg.sv]
`default_nettype none
package wpta_pkg;
  localparam int CoordBits = 12;
  localparam int CBits     = CoordBits + 1;    // stored coordinate, signed
  localparam int DBits     = CoordBits + 2;    // coordinate delta, signed
  localparam int SqBits    = 2 * CoordBits + 2; // sum of squares
  localparam int CordW     = DBits + 16 + 3;   // CORDIC datapath
  localparam int AngW      = 16;
  localparam int CordIters = 14;

  localparam logic signed [AngW-1:0] PiQ13     = 16'sd25736;
  localparam logic signed [AngW-1:0] HalfPiQ13 = 16'sd12868;
  localparam logic signed [17:0]     TwoPiQ13  = 18'sd51472;

  localparam logic [1:0] CfgMinDist    = 2'd0;
  localparam logic [1:0] CfgDistScale  = 2'd1;
  localparam logic [1:0] CfgAngleScale = 2'd2;

  function automatic logic [AngW-1:0] atan_lut(input logic [3:0] i);
    logic [AngW-1:0] v;
    case (i)
      4'd0: v = 16'd6434;
      4'd1: v = 16'd3798;
      4'd2: v = 16'd2007;
      4'd3: v = 16'd1019;
      4'd4: v = 16'd511;
      4'd5: v = 16'd256;
      4'd6: v = 16'd128;
      4'd7: v = 16'd64;
      4'd8: v = 16'd32;
      4'd9: v = 16'd16;
      4'd10: v = 16'd8;
      4'd11: v = 16'd4;
      4'd12: v = 16'd2;
      4'd13: v = 16'd1;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

[src/wpta_isqrt.sv]
`default_nettype none
// Digit-by-digit square root, one result bit per cycle.
module wpta_isqrt (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire  [47:0] rad_i,
  output logic        done_o,
  output logic [23:0] root_o
);
  logic [47:0] rem_q, rem_d;
  logic [23:0] root_q, root_d;
  logic [47:0] src_q, src_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [49:0] trial;
  logic [49:0] acc;

  always_comb begin
    rem_d  = rem_q;
    root_d = root_q;
    src_d  = src_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    acc    = {rem_q, src_q[47:46]};
    trial  = {24'd0, root_q, 2'b01};
    if (start_i) begin
      rem_d  = '0;
      root_d = '0;
      src_d  = rad_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      src_d = {src_q[45:0], 2'b00};
      if (acc >= trial) begin
        rem_d  = 48'(acc - trial);
        root_d = {root_q[22:0], 1'b1};
      end else begin
        rem_d  = acc[47:0];
        root_d = {root_q[22:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd23) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    src_q  <= src_d;
  end

  assign root_o = root_d;
endmodule
`default_nettype wire

[src/wpta_cordic.sv]
`default_nettype none
// CORDIC vectoring, one micro-rotation per cycle; heading in Q3.13.
module wpta_cordic
  import wpta_pkg::*;
(
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start_i,
  input  wire  signed [DBits-1:0]     vx_i,
  input  wire  signed [DBits-1:0]     vy_i,
  output logic                        done_o,
  output logic signed [AngW-1:0]      ang_o
);
  // iteration mark for a vertical vector: no rotation, finish next cycle
  localparam logic [3:0] IterSkip = 4'hF;

  logic signed [CordW-1:0] x_q, x_d, y_q, y_d, xs, ys, x0, y0;
  logic signed [AngW-1:0]  z_q, z_d;
  logic [3:0]              i_q, i_d;
  logic                    busy_q, busy_d;

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; i_d = i_q; busy_d = busy_q;
    done_o = 1'b0;
    x0 = CordW'(vx_i) <<< 16;
    y0 = CordW'(vy_i) <<< 16;
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
    if (busy_q) begin
      if (i_q == IterSkip) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        if (y_q > 0) begin
          x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + $signed(atan_lut(i_q));
        end else begin
          x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - $signed(atan_lut(i_q));
        end
        i_d = i_q + 4'd1;
        if (i_q == 4'(CordIters - 1)) begin
          busy_d = 1'b0;
          done_o = 1'b1;
        end
      end
    end
    // hand out the finished heading before a new start reloads the registers
    ang_o = z_d;
    if (start_i) begin
      busy_d = 1'b1;
      i_d = '0;
      if (vx_i == '0) begin
        z_d = (vy_i > 0) ? HalfPiQ13 : -HalfPiQ13;
        i_d = IterSkip;
      end else if (vx_i < 0) begin
        z_d = (vy_i >= 0) ? PiQ13 : -PiQ13;
        x_d = -x0; y_d = -y0;
      end else begin
        z_d = '0; x_d = x0; y_d = y0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q    <= '0;
    end else begin
      busy_q <= busy_d;
      i_q    <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
  end
endmodule
`default_nettype wire

[src/waypoint_to_turn_and_advance_top.sv]
`default_nettype none
// Waypoint to turn-and-advance converter.
// Input channel s_axis_*: one item per measured point. tdata holds
// offset_mm[11:0] (signed) then range_mm[23:12]; tuser holds new_path.
// Output channel m_axis_*: tdata holds advance_steps[15:0] then
// turn_steps[31:16] (signed). Config channel cfg_*: index 0 minimum spacing,
// 1 dist_scale, 2 angle_scale; other indexes are ignored. Write only while
// the block is idle; ready is held low while a point is in flight.
// Each point runs through the depth square root and the spacing check; a
// point that gives a result then runs the length square root, two CORDIC
// headings (a vertical vector skips the micro-rotations), the turn wrap and
// two serial scale multiplies, all sequential in one controller. The next
// item is accepted only once the point is stored or dropped, or once its
// result is taken. The bit-serial root, CORDIC and multiply are shared
// units. Only one item is in flight.
// A point too close to the last kept one is dropped with no result; the
// first two kept points of a path are stored and give no result.
// Reset clears the stored path and loads the register defaults. The result
// sits in an output register; while the receiver stalls, hold it and accept
// no new item until it is taken.
module waypoint_to_turn_and_advance_top
  import wpta_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,   // offset_mm[11:0], range_mm[23:12]
  input  wire  [0:0]  s_axis_tuser,   // new_path
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // advance_steps[15:0], turn_steps[31:16]
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [15:0] cfg_data_i
);
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDepth = 4'd1;
  localparam logic [3:0] StDist  = 4'd2;
  localparam logic [3:0] StLen   = 4'd3;
  localparam logic [3:0] StH2    = 4'd4;
  localparam logic [3:0] StH1    = 4'd5;
  localparam logic [3:0] StWrap  = 4'd6;
  localparam logic [3:0] StMulA  = 4'd7;
  localparam logic [3:0] StMulT  = 4'd8;
  localparam logic [3:0] StOut   = 4'd9;

  logic [3:0] st_q, st_d;
  logic [7:0]  spacing_q;
  logic [15:0] dist_scale_q, angle_scale_q;
  logic signed [CBits-1:0] lx_q, ly_q, bx_q, by_q, px_q, py_q;
  logic [1:0]  held_q;
  logic signed [DBits-1:0] dx_q, dy_q;
  logic [23:0] len_q;
  logic signed [AngW-1:0] h2_q;
  logic signed [17:0] t_q;
  logic [40:0] acc_q;      // serial product
  logic [4:0]  mcnt_q;
  logic [31:0] out_q;
  logic        out_v_q;

  // square root and CORDIC units
  logic        sq_start, sq_done;
  logic [47:0] sq_rad;
  logic [23:0] sq_root;
  logic        co_start, co_done;
  logic signed [DBits-1:0] co_vx, co_vy;
  logic signed [AngW-1:0]  co_ang;

  wpta_isqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .rad_i(sq_rad),
    .done_o(sq_done), .root_o(sq_root)
  );
  wpta_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(co_start), .vx_i(co_vx), .vy_i(co_vy),
    .done_o(co_done), .ang_o(co_ang)
  );

  logic signed [CoordBits-1:0] in_x;
  logic [CoordBits-1:0] in_r;
  logic signed [2*CoordBits+1:0] d2;
  assign in_x = $signed(s_axis_tdata[CoordBits-1:0]);
  assign in_r = s_axis_tdata[2*CoordBits-1:CoordBits];
  assign d2 = $signed({2'b00, 24'(in_r * in_r)}) - $signed(26'(in_x * in_x));

  assign s_axis_tready = (st_q == StIdle) && !out_v_q;
  assign cfg_ready_o   = (st_q == StIdle);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  logic s_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  logic [15:0] mul_b;
  logic [40:0] acc_add;
  logic [17:0] t_abs;
  logic signed [17:0] t_raw;
  logic [24:0] mag;
  logic [24:0] advr;
  logic [DBits*2-1:0] sq_x, sq_y;
  logic [SqBits-1:0] s_live;
  logic too_close;
  assign t_raw = 18'(h2_q) - 18'(co_ang);
  assign t_abs = t_q[17] ? 18'(-t_q) : t_q;
  assign mul_b = (st_q == StMulA) ? dist_scale_q : angle_scale_q;
  // shift-add: one multiplier bit a cycle, LSB first
  assign acc_add = mul_b[mcnt_q[3:0]]
    ? 41'(acc_q + (((st_q == StMulA) ? 41'(len_q) : 41'(t_abs)) << mcnt_q[3:0]))
    : acc_q;
  assign advr = 25'((acc_add + 41'd32768) >> 16);
  assign mag  = 25'((acc_add + 41'd1048576) >> 21);
  assign sq_x = dx_q * dx_q;
  assign sq_y = dy_q * dy_q;
  assign s_live = SqBits'(sq_x + sq_y);
  // drop the point when it lies within the minimum spacing of the last kept one
  assign too_close = (held_q != 2'd0) && (s_live < SqBits'(spacing_q * spacing_q));

  always_comb begin
    st_d = st_q;
    sq_start = 1'b0;
    sq_rad = '0;
    co_start = 1'b0;
    co_vx = dx_q;
    co_vy = dy_q;
    unique case (st_q)
      StIdle: if (s_fire) begin
        sq_start = 1'b1;
        sq_rad = (d2 > 0) ? 48'(d2) : '0;
        st_d = StDepth;
      end
      StDepth: if (sq_done) st_d = StDist;
      StDist: begin
        if (too_close) st_d = StIdle;
        else if (held_q != 2'd2) st_d = StIdle;
        else begin
          sq_start = 1'b1;
          sq_rad = 48'(s_live) << 16;
          st_d = StLen;
        end
      end
      StLen: if (sq_done) begin
        co_start = 1'b1;
        st_d = StH2;
      end
      StH2: if (co_done) begin
        co_start = 1'b1;
        co_vx = DBits'(lx_q) - DBits'(bx_q);
        co_vy = DBits'(ly_q) - DBits'(by_q);
        st_d = StH1;
      end
      StH1: begin
        co_vx = DBits'(lx_q) - DBits'(bx_q);
        co_vy = DBits'(ly_q) - DBits'(by_q);
        if (co_done) st_d = StWrap;
      end
      StWrap: st_d = StMulA;
      StMulA: if (mcnt_q == 5'd15) st_d = StMulT;
      StMulT: if (mcnt_q == 5'd15) st_d = StOut;
      StOut: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      spacing_q <= 8'd5;
      dist_scale_q <= 16'd1969;
      angle_scale_q <= 16'd52677;
      lx_q <= '0; ly_q <= '0; bx_q <= '0; by_q <= '0;
      held_q <= '0;
      out_v_q <= 1'b0;
      mcnt_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgMinDist:    spacing_q <= cfg_data_i[7:0];
          CfgDistScale:  dist_scale_q <= cfg_data_i;
          CfgAngleScale: angle_scale_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) out_v_q <= 1'b0;
      if (s_fire && s_axis_tuser[0]) held_q <= '0;
      // first or second point of a path: store it now
      if (st_q == StDist && !too_close && held_q != 2'd2) begin
        bx_q <= lx_q; by_q <= ly_q;
        lx_q <= px_q; ly_q <= py_q;
        held_q <= held_q + 2'd1;
      end
      if (st_q == StMulA || st_q == StMulT) mcnt_q <= (mcnt_q == 5'd15) ? '0 : mcnt_q + 5'd1;
      if (st_q == StOut) begin
        // advance the history once both headings are taken
        bx_q <= lx_q; by_q <= ly_q;
        lx_q <= px_q; ly_q <= py_q;
        out_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) px_q <= CBits'(in_x);
    if (st_q == StDepth && sq_done) begin
      py_q <= CBits'({1'b0, sq_root[CoordBits-1:0]});
      dx_q <= DBits'(px_q) - DBits'(lx_q);
      dy_q <= DBits'({1'b0, sq_root[CoordBits-1:0]}) - DBits'(ly_q);
    end
    if (st_q == StLen && sq_done) len_q <= sq_root;
    if (st_q == StH2 && co_done) h2_q <= co_ang;
    if (st_q == StH1 && co_done) begin
      t_q <= t_raw;
    end
    if (st_q == StWrap) begin
      if (t_q > 18'sd25736) t_q <= t_q - TwoPiQ13;
      else if (t_q < -18'sd25736) t_q <= t_q + TwoPiQ13;
      acc_q <= '0;
    end
    if (st_q == StMulA && mcnt_q == 5'd15) acc_q <= '0;
    else if (st_q == StMulA || st_q == StMulT) acc_q <= acc_add;
    if (st_q == StMulA && mcnt_q == 5'd15) begin
      out_q[15:0] <= (advr[24:16] != '0) ? 16'hFFFF : advr[15:0];
    end
    if (st_q == StMulT && mcnt_q == 5'd15) begin
      if (t_q[17]) out_q[31:16] <= (mag > 25'd32768) ? 16'h8000 : 16'(-mag);
      else out_q[31:16] <= (mag > 25'd32767) ? 16'h7FFF : mag[15:0];
    end
  end

  property p_no_accept_busy;
    @(posedge clk_i) disable iff (!rst_ni) (st_q != StIdle) |-> !s_axis_tready;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("ready while busy");

  property p_out_only_after;
    @(posedge clk_i) disable iff (!rst_ni) $rose(m_axis_tvalid) |-> $past(st_q) == StOut;
  endproperty
  a_out_only_after: assert property (p_out_only_after) else $error("stray result");

  property p_held_range;
    @(posedge clk_i) disable iff (!rst_ni) held_q != 2'd3;
  endproperty
  a_held_range: assert property (p_held_range) else $error("bad point count");
endmodule
`default_nettype wire
